### rtl/core/glr_pkg.sv
// ---------------------------------------------------------------------------
// glr_pkg - shared types and constants of the gradient line rasterizer
// Field widths, opcodes and the controller/datapath command bundle.
// ---------------------------------------------------------------------------
package glr_pkg;

  localparam int ScreenWidthDef  = 1024;
  localparam int ScreenHeightDef = 512;
  localparam int FracBitsDef     = 16;

  localparam int CoordW = 12;
  localparam int RgbW   = 24;
  localparam int IndexW = 19;
  localparam int CountW = 13;
  localparam int ChanW  = 8;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture endpoints, start root and divisions
    logic root_step; // one root iteration
    logic div_init;  // latch n, start divisions
    logic div_step;  // one division iteration
    logic emit;      // compute pixel into output register, advance
  } glr_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic root_done;
    logic div_done;
    logic active;    // pixels left and n nonzero
  } glr_sts_t;

endpackage

### rtl/core/glr_if.sv
// ---------------------------------------------------------------------------
// glr_in_if / glr_out_if - valid/ready channels of the rasterizer
// Input carries load/step words, output carries pixel words.
// ---------------------------------------------------------------------------
interface glr_in_if;
  logic                               valid;
  logic                               ready;
  logic                               opcode;
  logic signed [glr_pkg::CoordW-1:0]  start_x;
  logic signed [glr_pkg::CoordW-1:0]  start_y;
  logic signed [glr_pkg::CoordW-1:0]  end_x;
  logic signed [glr_pkg::CoordW-1:0]  end_y;
  logic        [glr_pkg::RgbW-1:0]    start_rgb;
  logic        [glr_pkg::RgbW-1:0]    end_rgb;
  modport source (output valid, opcode, start_x, start_y, end_x, end_y, start_rgb,
                  end_rgb, input ready);
  modport sink (input valid, opcode, start_x, start_y, end_x, end_y, start_rgb,
                end_rgb, output ready);
endinterface

interface glr_out_if;
  logic                        valid;
  logic                        ready;
  logic [glr_pkg::IndexW-1:0]  pixel_index;
  logic [glr_pkg::RgbW-1:0]    pixel_rgb;
  logic                        visible;
  logic                        last;
  modport source (output valid, pixel_index, pixel_rgb, visible, last, input ready);
  modport sink (input valid, pixel_index, pixel_rgb, visible, last, output ready);
endinterface

### rtl/core/glr_datapath.sv
// ---------------------------------------------------------------------------
// glr_datapath - line state, iterative root/divide and pixel stepping
// Root: 2 bits a cycle over 16 steps. Divides: one quotient bit a cycle on
// five lanes (x, y and the three color channels) sharing the divisor n.
// Colors step by incremental remainder accumulators, one add per pixel.
// ---------------------------------------------------------------------------
module glr_datapath #(
  parameter int SCREEN_WIDTH  = glr_pkg::ScreenWidthDef,
  parameter int SCREEN_HEIGHT = glr_pkg::ScreenHeightDef,
  parameter int FRAC_BITS     = glr_pkg::FracBitsDef
) (
  input  logic                              clk,
  input  logic                              rst,
  input  glr_pkg::glr_cmd_t                 cmd,
  output glr_pkg::glr_sts_t                 sts,
  input  logic signed [glr_pkg::CoordW-1:0] in_sx,
  input  logic signed [glr_pkg::CoordW-1:0] in_sy,
  input  logic signed [glr_pkg::CoordW-1:0] in_ex,
  input  logic signed [glr_pkg::CoordW-1:0] in_ey,
  input  logic [glr_pkg::RgbW-1:0]          in_from,
  input  logic [glr_pkg::RgbW-1:0]          in_to,
  output logic [glr_pkg::IndexW-1:0]        px_index,
  output logic [glr_pkg::RgbW-1:0]          px_rgb,
  output logic                              px_visible,
  output logic                              px_last
);
  localparam int CW   = glr_pkg::CountW;
  localparam int CH   = glr_pkg::ChanW;
  localparam int IW   = glr_pkg::IndexW;
  localparam int DW   = glr_pkg::CoordW + 1;             // |d| up to 4095
  localparam int PW   = glr_pkg::CoordW + 2 + FRAC_BITS; // position
  localparam int XW   = PW - FRAC_BITS;                  // whole pixels
  localparam int NUMW = DW + FRAC_BITS;                  // dividend bits
  localparam int QCW  = $clog2(NUMW + 1);
  localparam int RW   = CW + 1;                          // color remainder (< 2n)
  localparam int AW   = CW + 2;                          // remainder sum (< 4n)
  localparam int NL   = 5;                               // divider lanes

  // line geometry
  logic signed [DW-1:0]     dx, dy;
  logic [DW-1:0]            mag_x, mag_y;
  logic                     neg_x, neg_y;
  logic [31:0]              rt_v, rt_res, rt_bit;
  logic [4:0]               rt_cnt;
  logic [CW-1:0]            n, left;
  logic [QCW-1:0]           dcnt;
  logic signed [PW-1:0]     pos_x, pos_y;
  logic [glr_pkg::RgbW-1:0] from_c, to_c;

  // divider lanes: 0 = x, 1 = y, 2+c = color channel c
  logic [NUMW-1:0] dv_num [NL];
  logic [CW-1:0]   dv_rem [NL];
  logic [NUMW-1:0] dv_quo [NL];
  logic [CW:0]     dv_sh  [NL];
  logic            dv_ge  [NL];

  // color accumulators per channel
  logic [CH-1:0] cval      [3];
  logic [RW-1:0] crem      [3];
  logic          cneg      [3];
  logic [CH-1:0] cmag      [3];
  logic [RW-1:0] crs       [3];
  logic [RW-1:0] cmod      [3];
  logic [AW-1:0] csum      [3];
  logic          cwrap     [3];
  logic [CH-1:0] cstep     [3];
  logic [RW-1:0] crem_next [3];
  logic [CH-1:0] cval_next [3];

  // squared length terms
  logic signed [2*DW-1:0] sqx, sqy;
  assign sqx = dx * dx;
  assign sqy = dy * dy;

  always_comb begin
    sts.root_done = (rt_cnt == 5'd0);
    sts.div_done  = (dcnt == '0);
    sts.active    = (left != '0) && (n != '0);
  end

  // one root iteration
  logic [31:0] rt_try;
  assign rt_try = rt_res + rt_bit;

  // one restoring division iteration per lane
  always_comb begin
    for (int l = 0; l < NL; l++) begin
      dv_sh[l] = {dv_rem[l], dv_num[l][NUMW-1]};
      dv_ge[l] = (dv_sh[l] >= {1'b0, n});
    end
  end

  // signed per-pixel steps from the axis quotients
  logic signed [PW-1:0] step_x, step_y;
  assign step_x = neg_x ? -PW'(dv_quo[0]) : PW'(dv_quo[0]);
  assign step_y = neg_y ? -PW'(dv_quo[1]) : PW'(dv_quo[1]);

  // color stepping: rising channels round half up (modulus 2n, start n),
  // falling channels truncate (modulus n, start 0)
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      cneg[c] = to_c[CH*c +: CH] < from_c[CH*c +: CH];
      cmag[c] = cneg[c] ? from_c[CH*c +: CH] - to_c[CH*c +: CH]
                        : to_c[CH*c +: CH] - from_c[CH*c +: CH];
      crs[c]  = cneg[c] ? {1'b0, dv_rem[2+c]} : {dv_rem[2+c], 1'b0};
      cmod[c] = cneg[c] ? {1'b0, n} : {n, 1'b0};
      csum[c] = AW'(crem[c]) + AW'(crs[c]);
      cwrap[c] = (csum[c] >= AW'(cmod[c]));
      crem_next[c] = cwrap[c] ? RW'(csum[c] - AW'(cmod[c])) : RW'(csum[c]);
      cstep[c] = dv_quo[2+c][CH-1:0] + CH'(cwrap[c]);
      cval_next[c] = cneg[c] ? cval[c] - cstep[c] : cval[c] + cstep[c];
    end
  end

  // pixel position to whole pixels, truncated toward zero
  logic signed [XW-1:0] px, py;
  logic [PW-1:0] ax, ay;
  always_comb begin
    ax = pos_x[PW-1] ? PW'(-pos_x) : PW'(pos_x);
    ay = pos_y[PW-1] ? PW'(-pos_y) : PW'(pos_y);
    px = pos_x[PW-1] ? -XW'(ax >> FRAC_BITS) : XW'(ax >> FRAC_BITS);
    py = pos_y[PW-1] ? -XW'(ay >> FRAC_BITS) : XW'(ay >> FRAC_BITS);
  end

  logic vis;
  assign vis = (px >= 0) && (px < XW'(SCREEN_WIDTH)) && (py >= 0)
               && (py < XW'(SCREEN_HEIGHT));
  logic [IW-1:0] row;
  assign row = IW'(SCREEN_HEIGHT - 1) - IW'(py);

  always_ff @(posedge clk) begin
    if (rst) begin
      rt_cnt <= '0;
      dcnt   <= '0;
      n      <= '0;
      left   <= '0;
    end else begin
      // capture a new line
      if (cmd.load) begin
        dx      <= DW'(in_ex) - DW'(in_sx);
        dy      <= DW'(in_ey) - DW'(in_sy);
        pos_x   <= PW'(in_sx) <<< FRAC_BITS;
        pos_y   <= PW'(in_sy) <<< FRAC_BITS;
        from_c  <= in_from;
        to_c    <= in_to;
        left    <= '0;
        n       <= '0;
        rt_cnt  <= 5'd17;
        rt_res  <= '0;
        rt_bit  <= 32'h4000_0000;
      end
      // root: the first step latches d^2, then 16 iterations
      if (cmd.root_step) begin
        if (rt_cnt == 5'd17) begin
          rt_v   <= 32'(sqx) + 32'(sqy);
          neg_x  <= dx[DW-1];
          neg_y  <= dy[DW-1];
          mag_x  <= dx[DW-1] ? DW'(-dx) : DW'(dx);
          mag_y  <= dy[DW-1] ? DW'(-dy) : DW'(dy);
        end else if (rt_v >= rt_try) begin
          rt_v   <= rt_v - rt_try;
          rt_res <= (rt_res >> 1) + rt_bit;
          rt_bit <= rt_bit >> 2;
        end else begin
          rt_res <= rt_res >> 1;
          rt_bit <= rt_bit >> 2;
        end
        rt_cnt <= rt_cnt - 5'd1;
      end
      // latch n, load the divider lanes and the color accumulators
      if (cmd.div_init) begin
        n     <= CW'(rt_res);
        left  <= CW'(rt_res);
        dcnt  <= (rt_res[CW-1:0] == '0) ? '0 : QCW'(NUMW);
        dv_num[0] <= {mag_x, {FRAC_BITS{1'b0}}};
        dv_num[1] <= {mag_y, {FRAC_BITS{1'b0}}};
        for (int l = 0; l < NL; l++) begin
          dv_rem[l] <= '0;
          dv_quo[l] <= '0;
        end
        for (int c = 0; c < 3; c++) begin
          dv_num[2+c] <= NUMW'(cmag[c]);
          cval[c]     <= from_c[CH*c +: CH];
          crem[c]     <= cneg[c] ? '0 : RW'(rt_res[CW-1:0]);
        end
      end
      // one quotient bit per lane
      if (cmd.div_step) begin
        for (int l = 0; l < NL; l++) begin
          dv_rem[l] <= dv_ge[l] ? CW'(dv_sh[l] - {1'b0, n}) : dv_sh[l][CW-1:0];
          dv_quo[l] <= {dv_quo[l][NUMW-2:0], dv_ge[l]};
          dv_num[l] <= {dv_num[l][NUMW-2:0], 1'b0};
        end
        dcnt <= dcnt - 1'b1;
      end
      // emit one pixel and advance
      if (cmd.emit) begin
        px_index   <= vis ? IW'(row * IW'(SCREEN_WIDTH) + IW'(px)) : '0;
        px_visible <= vis;
        px_last    <= (left == CW'(1));
        pos_x      <= pos_x + step_x;
        pos_y      <= pos_y + step_y;
        left       <= left - 1'b1;
        for (int c = 0; c < 3; c++) begin
          px_rgb[CH*c +: CH] <= cval[c];
          cval[c]            <= cval_next[c];
          crem[c]            <= crem_next[c];
        end
      end
    end
  end

endmodule

### rtl/core/glr_ctrl.sv
// ---------------------------------------------------------------------------
// glr_ctrl - sequencer of the rasterizer
// Accepts words, runs root then divide on load, emits one pixel per step while a line is active.
// ---------------------------------------------------------------------------
module glr_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_opcode,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output glr_pkg::glr_cmd_t cmd,
  input  glr_pkg::glr_sts_t sts
);
  typedef enum logic [1:0] {S_IDLE, S_ROOT, S_DIV} state_t;
  state_t state;

  logic take;
  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready);
  assign take     = in_valid && in_ready;

  always_comb begin
    cmd           = '0;
    cmd.load      = take && (in_opcode == glr_pkg::OP_LOAD);
    cmd.emit      = take && (in_opcode == glr_pkg::OP_STEP) && sts.active;
    cmd.root_step = (state == S_ROOT) && !sts.root_done;
    cmd.div_init  = (state == S_ROOT) && sts.root_done;
    cmd.div_step  = (state == S_DIV) && !sts.div_done;
  end

  // hold state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (cmd.emit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: if (cmd.load) state <= S_ROOT;
        S_ROOT: if (sts.root_done) state <= S_DIV;
        S_DIV:  if (sts.div_done) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

### rtl/core/gradient_line_rasterizer_unit.sv
// ---------------------------------------------------------------------------
// gradient_line_rasterizer_unit - DDA line rasterizer with color gradient
// Channel  Dir  Carries
// in       in   load word (endpoints, colors) or step word
// out      out  pixel word (index, color, visible, last)
// A step word yields one pixel into the output register while a line is active.
// A load word holds the input after it is taken, through the root steps
// (latch d^2, then 16 two-bit iterations), a step to latch n, the divide
// iterations (one quotient bit each) and a step to return idle; no divides at length 0.
// Reset (rst, synchronous) leaves no line active.
// Input waits while the output register holds an untaken pixel.
// ---------------------------------------------------------------------------
module gradient_line_rasterizer_unit #(
  parameter int SCREEN_WIDTH  = glr_pkg::ScreenWidthDef,
  parameter int SCREEN_HEIGHT = glr_pkg::ScreenHeightDef,
  parameter int FRAC_BITS     = glr_pkg::FracBitsDef
) (
  input logic   clk,
  input logic   rst,
  glr_in_if.sink  in,
  glr_out_if.source out
);
  glr_pkg::glr_cmd_t cmd;
  glr_pkg::glr_sts_t sts;

  glr_ctrl u_ctrl (
    .clk, .rst,
    .in_valid(in.valid), .in_opcode(in.opcode), .in_ready(in.ready),
    .out_valid(out.valid), .out_ready(out.ready),
    .cmd, .sts
  );

  glr_datapath #(
    .SCREEN_WIDTH(SCREEN_WIDTH), .SCREEN_HEIGHT(SCREEN_HEIGHT), .FRAC_BITS(FRAC_BITS)
  ) u_dp (
    .clk, .rst, .cmd, .sts,
    .in_sx(in.start_x), .in_sy(in.start_y), .in_ex(in.end_x), .in_ey(in.end_y),
    .in_from(in.start_rgb), .in_to(in.end_rgb),
    .px_index(out.pixel_index), .px_rgb(out.pixel_rgb),
    .px_visible(out.visible), .px_last(out.last)
  );
endmodule

### tb/tb.sv
// ---------------------------------------------------------------------------
// tb - self-checking bench for the gradient line rasterizer unit
// Feeds load and step words through a valid/ready channel with random gaps,
// predicts every pixel word in a behavioral model kept in the bench, and
// compares each received pixel word field by field with the oldest prediction.
// ---------------------------------------------------------------------------
module tb;

  typedef struct packed {
    logic                              opcode;
    logic signed [glr_pkg::CoordW-1:0] start_x;
    logic signed [glr_pkg::CoordW-1:0] start_y;
    logic signed [glr_pkg::CoordW-1:0] end_x;
    logic signed [glr_pkg::CoordW-1:0] end_y;
    logic [glr_pkg::RgbW-1:0]          start_rgb;
    logic [glr_pkg::RgbW-1:0]          end_rgb;
  } cmd_word_t;

  typedef struct packed {
    logic [glr_pkg::IndexW-1:0] pixel_index;
    logic [glr_pkg::RgbW-1:0]   pixel_rgb;
    logic                       visible;
    logic                       last;
  } pixel_word_t;

  localparam int NumItems     = 650;
  localparam int QuietTail    = 80;
  localparam int StallLimit   = 5000;
  localparam int DrainCycles  = 100;
  localparam int FracB        = glr_pkg::FracBitsDef;

  logic clk;
  logic rst;

  glr_in_if  in_ch ();
  glr_out_if out_ch ();

  gradient_line_rasterizer_unit DUT (
    .clk (clk),
    .rst (rst),
    .in  (in_ch),
    .out (out_ch)
  );

  cmd_word_t   cmd_queue[$];
  pixel_word_t pixel_expect[$];
  int          num_errors;
  int          items_made;
  bit          feed_done;

  // line state mirrored from the block
  longint   line_px, line_py, line_dx_step, line_dy_step;
  int       line_len, line_left;
  logic [glr_pkg::RgbW-1:0] line_c0, line_c1;

  // clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic int line_root(longint v);
    int lo, hi, mid;
    lo = 0;
    hi = 8191;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      if (longint'(mid) * mid <= v) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  function automatic longint step_quotient(int d, int n);
    longint mag;
    mag = (d < 0) ? -d : d;
    mag = (mag << FracB) / n;
    return (d < 0) ? -mag : mag;
  endfunction

  function automatic longint whole_pixel(longint p);
    if (p >= 0) return p >>> FracB;
    return -((-p) >>> FracB);
  endfunction

  function automatic logic [glr_pkg::ChanW-1:0] blend_channel(int c0, int c1, int i,
                                                              int n);
    int diff, q;
    diff = c1 - c0;
    if (diff >= 0) begin
      q = (2 * i * diff + n) / (2 * n);
      return glr_pkg::ChanW'(c0 + q);
    end
    q = (i * (-diff)) / n;
    return glr_pkg::ChanW'(c0 - q);
  endfunction

  // advance the mirrored line state by one accepted word, queue any pixel
  task automatic rasterize_word(cmd_word_t w);
    int dx, dy, i;
    longint x, y, idx;
    pixel_word_t p;
    if (w.opcode == glr_pkg::OP_LOAD) begin
      dx = int'(w.end_x) - int'(w.start_x);
      dy = int'(w.end_y) - int'(w.start_y);
      line_len  = line_root(longint'(dx) * dx + longint'(dy) * dy);
      line_left = line_len;
      line_c0 = w.start_rgb;
      line_c1 = w.end_rgb;
      line_px = longint'(w.start_x) <<< FracB;
      line_py = longint'(w.start_y) <<< FracB;
      line_dx_step = (line_len != 0) ? step_quotient(dx, line_len) : 0;
      line_dy_step = (line_len != 0) ? step_quotient(dy, line_len) : 0;
      return;
    end
    if (line_left == 0 || line_len == 0) return;
    i = line_len - line_left;
    x = whole_pixel(line_px);
    y = whole_pixel(line_py);
    p.visible = (x >= 0 && x < glr_pkg::ScreenWidthDef && y >= 0 &&
                 y < glr_pkg::ScreenHeightDef);
    idx = p.visible ? (glr_pkg::ScreenHeightDef - 1 - y) * glr_pkg::ScreenWidthDef + x
                    : 0;
    p.pixel_index = glr_pkg::IndexW'(idx);
    p.pixel_rgb = {blend_channel(line_c0[23:16], line_c1[23:16], i, line_len),
                   blend_channel(line_c0[15:8], line_c1[15:8], i, line_len),
                   blend_channel(line_c0[7:0], line_c1[7:0], i, line_len)};
    p.last = (line_left == 1);
    pixel_expect.push_back(p);
    line_px += line_dx_step;
    line_py += line_dy_step;
    line_left--;
  endtask

  // queue one load word
  task automatic add_line(int sx, int sy, int ex, int ey, logic [glr_pkg::RgbW-1:0] c0,
                          logic [glr_pkg::RgbW-1:0] c1);
    cmd_word_t w;
    w.opcode = glr_pkg::OP_LOAD;
    w.start_x = glr_pkg::CoordW'(sx);
    w.start_y = glr_pkg::CoordW'(sy);
    w.end_x = glr_pkg::CoordW'(ex);
    w.end_y = glr_pkg::CoordW'(ey);
    w.start_rgb = c0;
    w.end_rgb = c1;
    cmd_queue.push_back(w);
    items_made++;
  endtask

  // queue step words with random ignored fields
  task automatic add_steps(int k);
    cmd_word_t w;
    repeat (k) begin
      w = cmd_word_t'({$urandom, $urandom, $urandom, 1'b1});
      w.opcode = glr_pkg::OP_STEP;
      cmd_queue.push_back(w);
      items_made++;
    end
  endtask

  function automatic int line_steps(int sx, int sy, int ex, int ey);
    return line_root(longint'(ex - sx) * (ex - sx) + longint'(ey - sy) * (ey - sy));
  endfunction

  // no idling once the run reaches its tail
  function automatic bit in_tail();
    return feed_done && (cmd_queue.size() < QuietTail);
  endfunction

  // input driver with random idle bursts
  int  in_idle;

  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      in_idle <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) rasterize_word(cmd_word_t'({in_ch.opcode,
        in_ch.start_x, in_ch.start_y, in_ch.end_x, in_ch.end_y, in_ch.start_rgb,
        in_ch.end_rgb}));
      if (!in_ch.valid || in_ch.ready) begin
        if (in_idle > 0) begin
          in_idle <= in_idle - 1;
          in_ch.valid <= 1'b0;
        end else if (!in_tail() && $urandom_range(0, 5) == 0) begin
          in_idle <= $urandom_range(0, 5);
          in_ch.valid <= 1'b0;
        end else if (cmd_queue.size() > 0) begin
          cmd_word_t w;
          w = cmd_queue.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.opcode <= w.opcode;
          in_ch.start_x <= w.start_x;
          in_ch.start_y <= w.start_y;
          in_ch.end_x <= w.end_x;
          in_ch.end_y <= w.end_y;
          in_ch.start_rgb <= w.start_rgb;
          in_ch.end_rgb <= w.end_rgb;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // output monitor with random stall bursts
  int out_stall;
  int idle_cycles;

  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      out_stall <= 0;
      idle_cycles <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        pixel_word_t e;
        if (pixel_expect.size() == 0) begin
          $display("%0t: unexpected pixel word idx=%0h rgb=%0h vis=%0b last=%0b",
                   $time, out_ch.pixel_index, out_ch.pixel_rgb, out_ch.visible,
                   out_ch.last);
          num_errors++;
        end else begin
          e = pixel_expect.pop_front();
          if (out_ch.pixel_index !== e.pixel_index) begin
            $display("%0t: pixel_index expected %0h actual %0h", $time,
                     e.pixel_index, out_ch.pixel_index);
            num_errors++;
          end
          if (out_ch.pixel_rgb !== e.pixel_rgb) begin
            $display("%0t: pixel_rgb expected %0h actual %0h", $time,
                     e.pixel_rgb, out_ch.pixel_rgb);
            num_errors++;
          end
          if (out_ch.visible !== e.visible) begin
            $display("%0t: visible expected %0b actual %0b", $time, e.visible,
                     out_ch.visible);
            num_errors++;
          end
          if (out_ch.last !== e.last) begin
            $display("%0t: last expected %0b actual %0b", $time, e.last, out_ch.last);
            num_errors++;
          end
        end
      end
      if (out_stall > 0) begin
        out_stall <= out_stall - 1;
        out_ch.ready <= 1'b0;
      end else if (!in_tail() && $urandom_range(0, 5) == 0) begin
        out_stall <= $urandom_range(0, 5);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
      // watchdog on cycles with no accepted word
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // stimulus and end of run
  initial begin
    int sx, sy, ex, ey, n, kind;
    in_ch.valid = 1'b0;
    in_ch.opcode = glr_pkg::OP_STEP;
    in_ch.start_x = '0;
    in_ch.start_y = '0;
    in_ch.end_x = '0;
    in_ch.end_y = '0;
    in_ch.start_rgb = '0;
    in_ch.end_rgb = '0;
    out_ch.ready = 1'b0;
    num_errors = 0;
    items_made = 0;
    feed_done = 0;
    line_px = 0; line_py = 0; line_dx_step = 0; line_dy_step = 0;
    line_len = 0; line_left = 0; line_c0 = '0; line_c1 = '0;
    rst = 1'b1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // step before any line is loaded
    add_steps(2);
    // short line in the window, colors rising and falling
    add_line(10, 20, 16, 28, 24'h00FF80, 24'hFF0081);
    add_steps(11);
    // zero length, then steps that draw nothing
    add_line(5, 5, 5, 5, 24'h123456, 24'h654321);
    add_steps(2);
    // extreme corners, abandoned after a few pixels
    add_line(-2048, -2048, 2047, 2047, 24'hFFFFFF, 24'h000000);
    add_steps(2);
    add_line(2047, -2048, -2048, 2047, 24'h000000, 24'hFFFFFF);
    add_steps(2);
    // crossing the window edges, partly outside
    add_line(-3, 510, 3, 514, 24'hFF00FF, 24'h00FF00);
    add_steps(1);
    add_line(1021, -2, 1026, 2, 24'h0000FF, 24'hFF0000);
    add_steps(1);
    feed_done = 0;

    while (items_made < NumItems) begin
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        // random load anywhere, few steps, likely abandoned
        add_line($urandom_range(0, 4095) - 2048, $urandom_range(0, 4095) - 2048,
                 $urandom_range(0, 4095) - 2048, $urandom_range(0, 4095) - 2048,
                 glr_pkg::RgbW'($urandom), glr_pkg::RgbW'($urandom));
        add_steps($urandom_range(0, 3));
      end else if (kind == 1) begin
        add_steps($urandom_range(1, 2));
      end else begin
        // well-formed short line near the window, usually fully drawn
        sx = $urandom_range(0, 1064) - 20;
        sy = $urandom_range(0, 552) - 20;
        ex = sx + $urandom_range(0, 60) - 30;
        ey = sy + $urandom_range(0, 60) - 30;
        add_line(sx, sy, ex, ey, glr_pkg::RgbW'($urandom), glr_pkg::RgbW'($urandom));
        n = line_steps(sx, sy, ex, ey);
        if ($urandom_range(0, 7) == 0 && n > 1) n = $urandom_range(1, n - 1);
        else n = n + $urandom_range(0, 1);
        add_steps(n);
      end
    end
    feed_done = 1;

    while (!(cmd_queue.size() == 0 && !in_ch.valid && pixel_expect.size() == 0))
      @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (num_errors == 0 && pixel_expect.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
